// ----- hdl/fat16_cluster_chain_engine_core_assert.svh -----
// Assertion macros used by the checker file
`ifndef FAT16_CLUSTER_CHAIN_ENGINE_CORE_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_ENGINE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define FCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication outside reset
`define FCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ----- hdl/fce_pkg.sv -----
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types and constants of the FAT16 cluster chain engine.
// ----------------------------------------------------------------------------
package fce_pkg;
	localparam int TableEntries = 4096;
	localparam int AW = $clog2(TableEntries);

	localparam logic [2:0] OP_GET    = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_ALLOC  = 3'd2;
	localparam logic [2:0] OP_FREE   = 3'd3;
	localparam logic [2:0] OP_EXTEND = 3'd4;
	localparam logic [2:0] OP_LOCATE = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_CHAIN = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_CSIZE = 2'd1;
	localparam logic [1:0] REG_DATA  = 2'd2;
	localparam logic [1:0] REG_ROOT  = 2'd3;

	localparam logic [15:0] ALLOC_MARK = 16'hFFFF;
	localparam logic [15:0] LINK_LIMIT = 16'hFFF0;
	localparam logic [15:0] END_MIN    = 16'hFFF8;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] cluster;
		logic [15:0] entry_value;
		logic [26:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [15:0] cluster_out;
		logic [15:0] value_out;
		logic [31:0] sector_lba;
		logic [1:0]  status;
	} rsp_t;

	function automatic logic valid_link(input logic [15:0] v);
		return (v >= 16'd2) && (v < LINK_LIMIT);
	endfunction
endpackage

// ----- hdl/fce_table.sv -----
// ----------------------------------------------------------------------------
// fce_table
// Allocation table memory with a clearing pass after reset; one port,
// registered read data.
// ----------------------------------------------------------------------------
module fce_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   we,
	input  logic [fce_pkg::AW-1:0] addr,
	input  logic [15:0]            wdata,
	output logic [15:0]            rdata,
	output logic                   busy
);
	logic [15:0]            mem [fce_pkg::TableEntries];
	logic [fce_pkg::AW:0]   clr_q;

	// sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[fce_pkg::AW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign busy = !clr_q[fce_pkg::AW];

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[fce_pkg::AW-1:0]] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/fat16_cluster_chain_engine_core.sv -----
// ----------------------------------------------------------------------------
// fat16_cluster_chain_engine_core
// FAT16 table engine: get, set, allocate, free, extend and locate.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass zeroes the table before
// the first word is taken. A get passes through dispatch, read, evaluate and
// done; a set, an out-of-range index or an unknown opcode goes from dispatch
// straight to done. Allocation, free, extend and locate walk the single table
// port, each entry visited by an address state and then a registered-read
// state. The result word waits in an output register until taken, and the
// next word is taken no earlier than the edge after the result goes.
module fat16_cluster_chain_engine_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fce_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output fce_pkg::rsp_t  out_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	localparam int AW = fce_pkg::AW;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_RD, S_EVAL, S_SCAN_RD, S_SCAN_EV, S_LINK, S_DONE
	} state_t;

	state_t          state_q;
	logic [15:0]     count_q;
	logic [2:0]      csz_q;
	logic [31:0]     data_q, root_q;
	fce_pkg::req_t   req_q;
	logic [15:0]     n_q, tail_q, vcnt_q;
	logic [16:0]     hops_q;
	logic [26:0]     step_q;
	logic [16:0]     scan_q, scan_end_q;
	logic            tbl_we;
	logic [AW-1:0]   tbl_addr;
	logic [15:0]     tbl_wdata, tbl_rdata;
	logic            tbl_busy;
	fce_pkg::rsp_t   rsp_q;
	logic            out_q;
	logic [26:0]     sec;
	logic [26:0]     step_w;
	logic [17:0]     end_w;

	fce_table u_table (
		.clk(clk), .arst_n(arst_n), .we(tbl_we), .addr(tbl_addr),
		.wdata(tbl_wdata), .rdata(tbl_rdata), .busy(tbl_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd4094;
			csz_q   <= 3'd2;
			data_q  <= '0;
			root_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fce_pkg::REG_COUNT: count_q <= cfg_data[15:0];
				fce_pkg::REG_CSIZE: csz_q   <= cfg_data[2:0];
				fce_pkg::REG_DATA:  data_q  <= cfg_data;
				fce_pkg::REG_ROOT:  root_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_q || tbl_busy;
	assign out_valid = out_q;
	assign out_data  = rsp_q;
	assign sec       = {4'd0, req_q.entry_index[26:4]};
	assign step_w    = req_q.entry_index >> (5'd4 + {2'd0, csz_q});
	assign end_w     = 18'd2 + {2'd0, count_q};

	// table port: address comes from the walk pointer, the scan index or, when extend links, the tail
	always_comb begin
		tbl_we    = 1'b0;
		tbl_wdata = '0;
		tbl_addr  = n_q[AW-1:0];
		case (state_q)
			S_DISP: begin
				if (req_q.opcode == fce_pkg::OP_SET &&
				    {1'b0, req_q.cluster} < 17'(fce_pkg::TableEntries)) begin
					tbl_we    = 1'b1;
					tbl_wdata = req_q.entry_value;
				end
			end
			S_EVAL: begin
				if (req_q.opcode == fce_pkg::OP_FREE) begin
					tbl_we = 1'b1;
				end
			end
			S_SCAN_RD: tbl_addr = scan_q[AW-1:0];
			S_SCAN_EV: begin
				tbl_addr = scan_q[AW-1:0];
				if (tbl_rdata == 16'd0) begin
					tbl_we    = 1'b1;
					tbl_wdata = fce_pkg::ALLOC_MARK;
				end
			end
			S_LINK: begin
				// only extend links the new cluster after the tail
				if (req_q.opcode == fce_pkg::OP_EXTEND) begin
					tbl_we    = 1'b1;
					tbl_addr  = tail_q[AW-1:0];
					tbl_wdata = scan_q[15:0];
				end
			end
			default: ;
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_q   <= 1'b0;
		end else begin
			if (out_q && !out_stall) out_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q   <= in_data;
						n_q     <= in_data.cluster;
						vcnt_q  <= '0;
						hops_q  <= '0;
						rsp_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					scan_q     <= 17'd2;
					scan_end_q <= (end_w > 18'(fce_pkg::TableEntries)) ?
					              17'(fce_pkg::TableEntries) : end_w[16:0];
					step_q     <= step_w;
					state_q    <= S_RD;
					case (req_q.opcode)
						fce_pkg::OP_GET, fce_pkg::OP_SET: begin
							if ({1'b0, req_q.cluster} >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_RANGE;
								state_q <= S_DONE;
							end else if (req_q.opcode == fce_pkg::OP_SET) begin
								state_q <= S_DONE;
							end
						end
						fce_pkg::OP_ALLOC: state_q <= S_SCAN_RD;
						fce_pkg::OP_FREE: begin
							if (!fce_pkg::valid_link(n_q)) state_q <= S_DONE;
							else if ({1'b0, n_q} >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_RANGE;
								state_q <= S_DONE;
							end
						end
						fce_pkg::OP_EXTEND: begin
							if (!fce_pkg::valid_link(n_q)) begin
								rsp_q.status <= fce_pkg::ST_CHAIN;
								state_q <= S_DONE;
							end else if ({1'b0, n_q} >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_RANGE;
								state_q <= S_DONE;
							end
						end
						fce_pkg::OP_LOCATE: begin
							if (req_q.cluster == 16'd0) begin
								rsp_q.sector_lba <= root_q + {5'd0, sec};
								state_q <= S_DONE;
							end else if ({1'b0, step_w} + 28'd3 >
							             28'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_CHAIN;
								state_q <= S_DONE;
							end else if (step_w == '0) begin
								state_q <= S_LINK;
							end else if ({1'b0, n_q} >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_RANGE;
								state_q <= S_DONE;
							end
						end
						default: begin
							rsp_q.status <= fce_pkg::ST_RANGE;
							state_q <= S_DONE;
						end
					endcase
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					state_q <= S_RD;
					case (req_q.opcode)
						fce_pkg::OP_GET: begin
							rsp_q.value_out <= tbl_rdata;
							state_q <= S_DONE;
						end
						fce_pkg::OP_FREE: begin
							rsp_q.value_out <= vcnt_q + 16'd1;
							vcnt_q <= vcnt_q + 16'd1;
							n_q    <= tbl_rdata;
							if (tbl_rdata >= fce_pkg::END_MIN) state_q <= S_DONE;
							else if (!fce_pkg::valid_link(tbl_rdata)) begin
								rsp_q.status <= fce_pkg::ST_CHAIN;
								state_q <= S_DONE;
							end else if ({1'b0, tbl_rdata} >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_RANGE;
								state_q <= S_DONE;
							end
						end
						fce_pkg::OP_EXTEND: begin
							if (tbl_rdata >= fce_pkg::END_MIN) begin
								tail_q  <= n_q;
								state_q <= S_SCAN_RD;
							end else if (!fce_pkg::valid_link(tbl_rdata) ||
							             hops_q >= 17'(fce_pkg::TableEntries)) begin
								rsp_q.status <= fce_pkg::ST_CHAIN;
								state_q <= S_DONE;
							end else begin
								n_q    <= tbl_rdata;
								hops_q <= hops_q + 17'd1;
								if ({1'b0, tbl_rdata} >= 17'(fce_pkg::TableEntries)) begin
									rsp_q.status <= fce_pkg::ST_RANGE;
									state_q <= S_DONE;
								end
							end
						end
						default: begin
							// locate: one hop
							if (!fce_pkg::valid_link(tbl_rdata)) begin
								rsp_q.status <= fce_pkg::ST_CHAIN;
								state_q <= S_DONE;
							end else begin
								n_q    <= tbl_rdata;
								step_q <= step_q - 27'd1;
								if (step_q == 27'd1) state_q <= S_LINK;
								else if ({1'b0, tbl_rdata} >= 17'(fce_pkg::TableEntries)) begin
									rsp_q.status <= fce_pkg::ST_RANGE;
									state_q <= S_DONE;
								end
							end
						end
					endcase
				end
				S_SCAN_RD: begin
					if (scan_q >= scan_end_q) begin
						rsp_q.status <= fce_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					if (tbl_rdata == 16'd0) begin
						rsp_q.cluster_out <= scan_q[15:0];
						state_q <= (req_q.opcode == fce_pkg::OP_EXTEND) ? S_LINK : S_DONE;
					end else begin
						scan_q  <= scan_q + 17'd1;
						state_q <= S_SCAN_RD;
					end
				end
				S_LINK: begin
					// extend writes the link here; locate forms the sector
					if (req_q.opcode == fce_pkg::OP_LOCATE) begin
						rsp_q.cluster_out <= n_q;
						rsp_q.sector_lba <= data_q +
							(({16'd0, n_q} - 32'd2) << csz_q) +
							({5'd0, sec} & ((32'd1 << csz_q) - 32'd1));
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_q) begin
						out_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/fce_checker.sv -----
// ----------------------------------------------------------------------------
// fce_checker
// Port-level checks of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "fat16_cluster_chain_engine_core_assert.svh"
module fce_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input fce_pkg::rsp_t out_data
);
	// a waiting result word holds
	`FCE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	// no word taken while a result waits
	`FCE_ASSERT_IMPL(a_busy_stall, clk, arst_n, out_valid, in_stall)
	// an accepted word closes input for the next cycle
	`FCE_ASSERT_NEXT(a_one_at_time, clk, arst_n, in_valid && !in_stall, in_stall)
	// a result never appears in the cycle after a word is accepted
	`FCE_ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid)
endmodule

bind fat16_cluster_chain_engine_core fce_checker u_fce_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
